// ===== rtl/core/mko_pkg.sv =====
`timescale 1ns / 1ps

package mko_pkg;

  localparam int IN_W         = 24;
  localparam int HEAD_W       = 31;
  localparam int HSS_W        = 18;
  localparam int IHS_W        = 20;
  localparam int TP_W         = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;
  localparam int ANG_W        = 32;
  localparam int CS_W         = 25;
  localparam int CORDIC_STEPS = 24;

  localparam logic signed [ANG_W-1:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 32'sd1686629714;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 32'sd163008218;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_SPAN_SUM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_HALF_SPAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD       = 2'd2;

  localparam logic [HSS_W-1:0] HSS_RESET = 18'd27984;
  localparam logic [IHS_W-1:0] IHS_RESET = 20'd153480;
  localparam logic [TP_W-1:0]  TP_RESET  = 24'd16777;

  typedef enum logic [2:0] {
    F_IDLE,
    F_LZ,
    F_WHEEL,
    F_BODY,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL_T,
    B_MUL_X,
    B_MUL_Y,
    B_WRAP,
    B_FOLD,
    B_CORDIC,
    B_MUL_XC,
    B_MUL_YS,
    B_MUL_XS,
    B_MUL_YC,
    B_SUM,
    B_UPD
  } back_state_t;

  function automatic logic signed [ANG_W-1:0] atan_q28(input logic [4:0] i);
    case (i)
      5'd0:    return 32'sd210828714;
      5'd1:    return 32'sd124459457;
      5'd2:    return 32'sd65760959;
      5'd3:    return 32'sd33381290;
      5'd4:    return 32'sd16755422;
      5'd5:    return 32'sd8385879;
      5'd6:    return 32'sd4193963;
      5'd7:    return 32'sd2097109;
      5'd8:    return 32'sd1048571;
      5'd9:    return 32'sd524287;
      5'd10:   return 32'sd262144;
      5'd11:   return 32'sd131072;
      5'd12:   return 32'sd65536;
      5'd13:   return 32'sd32768;
      5'd14:   return 32'sd16384;
      5'd15:   return 32'sd8192;
      5'd16:   return 32'sd4096;
      5'd17:   return 32'sd2048;
      5'd18:   return 32'sd1024;
      5'd19:   return 32'sd512;
      5'd20:   return 32'sd256;
      5'd21:   return 32'sd128;
      5'd22:   return 32'sd64;
      5'd23:   return 32'sd32;
      default: return 32'sd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/mko_cmd_if.sv =====
`timescale 1ns / 1ps

interface mko_cmd_if import mko_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] vel_forward;
  logic signed [IN_W-1:0] vel_lateral;
  logic signed [IN_W-1:0] vel_turn;

  modport source(output valid, output vel_forward, output vel_lateral, output vel_turn,
                 input ready);
  modport sink(input valid, input vel_forward, input vel_lateral, input vel_turn,
               output ready);
endinterface

// ===== rtl/core/mko_res_if.sv =====
`timescale 1ns / 1ps

interface mko_res_if import mko_pkg::*; #(
  parameter int VEL_WIDTH = 24,
  parameter int POS_WIDTH = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [VEL_WIDTH-1:0] wheel_upper_left;
  logic signed [VEL_WIDTH-1:0] wheel_upper_right;
  logic signed [VEL_WIDTH-1:0] wheel_lower_left;
  logic signed [VEL_WIDTH-1:0] wheel_lower_right;
  logic signed [POS_WIDTH-1:0] pose_x;
  logic signed [POS_WIDTH-1:0] pose_y;
  logic signed [HEAD_W-1:0]    pose_heading;
  logic signed [VEL_WIDTH-1:0] body_vel_x;
  logic signed [VEL_WIDTH-1:0] body_vel_y;
  logic signed [VEL_WIDTH-1:0] body_vel_turn;

  modport source(output valid, output wheel_upper_left, output wheel_upper_right,
                 output wheel_lower_left, output wheel_lower_right, output pose_x,
                 output pose_y, output pose_heading, output body_vel_x,
                 output body_vel_y, output body_vel_turn, input ready);
  modport sink(input valid, input wheel_upper_left, input wheel_upper_right,
               input wheel_lower_left, input wheel_lower_right, input pose_x,
               input pose_y, input pose_heading, input body_vel_x,
               input body_vel_y, input body_vel_turn, output ready);
endinterface

// ===== rtl/core/mko_cfg_if.sv =====
`timescale 1ns / 1ps

interface mko_cfg_if import mko_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mko_front.sv =====
`timescale 1ns / 1ps

module mko_front import mko_pkg::*; #(
  parameter int VEL_WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [HSS_W-1:0]         half_span_sum,
  input  logic [IHS_W-1:0]         inverse_half_span,
  mko_cmd_if.sink                  cmd,
  output logic                     push_valid,
  input  logic                     push_ready,
  output logic [7*VEL_WIDTH-1:0]   push_data
);

  localparam int BIG_W = VEL_WIDTH + 24;
  localparam logic signed [BIG_W-1:0] VMAX = BIG_W'((64'sd1 <<< (VEL_WIDTH-1)) - 64'sd1);
  localparam logic signed [BIG_W-1:0] VMIN = -VMAX - BIG_W'(1);

  front_state_t state, state_next;

  logic signed [IN_W-1:0]      vf, vl, vt;
  logic signed [42:0]          lz_prod;
  logic signed [26:0]          lz;
  logic signed [VEL_WIDTH-1:0] ul, ur, ll, lr, bx, by, bt;
  logic signed [BIG_W-1:0]     bt_prod;
  logic signed [BIG_W-1:0]     w_ul, w_ur, w_ll, w_lr;
  logic signed [BIG_W-1:0]     sum_x, sum_y, diff_t;

  function automatic logic signed [VEL_WIDTH-1:0] sat_vel(input logic signed [BIG_W-1:0] v);
    if (v > VMAX) begin
      return VEL_WIDTH'(VMAX);
    end else if (v < VMIN) begin
      return VEL_WIDTH'(VMIN);
    end
    return VEL_WIDTH'(v);
  endfunction

  always_comb begin
    lz     = 27'((lz_prod + 43'sd32768) >>> 16);
    w_ul   = BIG_W'(vf) - BIG_W'(vl) - BIG_W'(lz);
    w_ur   = BIG_W'(vf) + BIG_W'(vl) + BIG_W'(lz);
    w_ll   = BIG_W'(vf) + BIG_W'(vl) - BIG_W'(lz);
    w_lr   = BIG_W'(vf) - BIG_W'(vl) + BIG_W'(lz);
    sum_x  = BIG_W'(ul) + BIG_W'(ur) + BIG_W'(ll) + BIG_W'(lr);
    sum_y  = -BIG_W'(ul) + BIG_W'(ur) + BIG_W'(ll) - BIG_W'(lr);
    diff_t = -BIG_W'(ul) + BIG_W'(ur) - BIG_W'(ll) + BIG_W'(lr);
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (cmd.valid) state_next = F_LZ;
      F_LZ:    state_next = F_WHEEL;
      F_WHEEL: state_next = F_BODY;
      F_BODY:  state_next = F_PUSH;
      F_PUSH:  if (push_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready  = (state == F_IDLE);
    push_valid = (state == F_PUSH);
    bt         = sat_vel((bt_prod + BIG_W'(131072)) >>> 18);
    push_data  = {ul, ur, ll, lr, bx, by, bt};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (cmd.valid) begin
          vf <= cmd.vel_forward;
          vl <= cmd.vel_lateral;
          vt <= cmd.vel_turn;
        end
      end
      F_LZ: begin
        lz_prod <= 43'(vt) * 43'($signed({1'b0, half_span_sum}));
      end
      F_WHEEL: begin
        ul <= sat_vel(w_ul);
        ur <= sat_vel(w_ur);
        ll <= sat_vel(w_ll);
        lr <= sat_vel(w_lr);
      end
      F_BODY: begin
        bx      <= sat_vel((sum_x + BIG_W'(2)) >>> 2);
        by      <= sat_vel((sum_y + BIG_W'(2)) >>> 2);
        bt_prod <= diff_t * BIG_W'($signed({1'b0, inverse_half_span}));
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/mko_queue.sv =====
`timescale 1ns / 1ps

module mko_queue import mko_pkg::*; #(
  parameter int DATA_W = 168
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] entries [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        count;
  logic              do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/core/mko_back.sv =====
`timescale 1ns / 1ps

module mko_back import mko_pkg::*; #(
  parameter int VEL_WIDTH = 24,
  parameter int POS_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [TP_W-1:0]        tick_period,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  logic [7*VEL_WIDTH-1:0] pop_data,
  mko_res_if.source              res
);

  localparam int DTH_W  = VEL_WIDTH + 13;
  localparam int DX_W   = VEL_WIDTH + 9;
  localparam int MA_W   = DX_W;
  localparam int MB_W   = CS_W;
  localparam int P_W    = MA_W + MB_W;
  localparam int SUM_W  = P_W + 1;
  localparam int HW     = ((DTH_W > 31) ? DTH_W : 31) + 2;
  localparam int RW     = HW + 1;
  localparam int K      = HW - 31;
  localparam int STEP_W = $clog2(((K > CORDIC_STEPS-1) ? K : CORDIC_STEPS-1) + 1);
  localparam int RND_W  = SUM_W - 28;
  localparam int AW     = ((POS_WIDTH > RND_W) ? POS_WIDTH : RND_W) + 1;
  localparam logic signed [AW-1:0] PMAX = AW'((64'sd1 <<< (POS_WIDTH-1)) - 64'sd1);
  localparam logic signed [AW-1:0] PMIN = -PMAX - AW'(1);

  back_state_t state, state_next;

  logic signed [VEL_WIDTH-1:0] ul, ur, ll, lr, bx, by, bt;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b, tp_s;
  logic                        mul_en;
  logic signed [P_W-1:0]       prod;
  logic signed [DTH_W-1:0]     dth;
  logic signed [DX_W-1:0]      dx, dy;
  logic signed [RW-1:0]        r_mid, r_new, pk, m_fix, n_fix;
  logic [STEP_W-1:0]           step;
  logic signed [ANG_W-1:0]     mid_ang, x, y, z, xs, ys, at, negx, negy;
  logic                        neg;
  logic signed [HEAD_W-1:0]    heading_new;
  logic signed [CS_W-1:0]      c_r, s_r;
  logic signed [SUM_W-1:0]     sumx, sumy;
  logic signed [RND_W-1:0]     rx, ry;
  logic signed [POS_WIDTH-1:0] acc_x, acc_y, new_x, new_y;
  logic signed [HEAD_W-1:0]    acc_heading;
  logic                        out_valid, out_free;

  function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [AW-1:0] v);
    if (v > PMAX) begin
      return POS_WIDTH'(PMAX);
    end else if (v < PMIN) begin
      return POS_WIDTH'(PMIN);
    end
    return POS_WIDTH'(v);
  endfunction

  always_comb begin
    tp_s    = MB_W'($signed({1'b0, tick_period}));
    pk      = RW'(TWO_PI_Q28) <<< step;
    m_fix   = (r_mid < 0) ? r_mid + RW'(TWO_PI_Q28) : r_mid;
    n_fix   = (r_new < 0) ? r_new + RW'(TWO_PI_Q28) : r_new;
    mid_ang = ANG_W'(m_fix - RW'(PI_Q28));
    xs      = x >>> step;
    ys      = y >>> step;
    at      = atan_q28(step[4:0]);
    negx    = neg ? -x : x;
    negy    = neg ? -y : y;
    c_r     = CS_W'((33'(negx) + 33'sd128) >>> 8);
    s_r     = CS_W'((33'(negy) + 33'sd128) >>> 8);
    rx      = RND_W'((sumx + SUM_W'(2**27)) >>> 28);
    ry      = RND_W'((sumy + SUM_W'(2**27)) >>> 28);
    new_x   = sat_pos(AW'(acc_x) + AW'(rx));
    new_y   = sat_pos(AW'(acc_y) + AW'(ry));
    out_free = !out_valid || res.ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:   if (pop_valid) state_next = B_MUL_T;
      B_MUL_T:  state_next = B_MUL_X;
      B_MUL_X:  state_next = B_MUL_Y;
      B_MUL_Y:  state_next = B_WRAP;
      B_WRAP:   if (step == '0) state_next = B_FOLD;
      B_FOLD:   state_next = B_CORDIC;
      B_CORDIC: if (step == STEP_W'(CORDIC_STEPS-1)) state_next = B_MUL_XC;
      B_MUL_XC: state_next = B_MUL_YS;
      B_MUL_YS: state_next = B_MUL_XS;
      B_MUL_XS: state_next = B_MUL_YC;
      B_MUL_YC: state_next = B_SUM;
      B_SUM:    state_next = B_UPD;
      B_UPD:    if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (state == B_IDLE);
    mul_en    = 1'b1;
    mul_a     = MA_W'(bt);
    mul_b     = tp_s;
    case (state)
      B_MUL_T: begin
        mul_a = MA_W'(bt);
        mul_b = tp_s;
      end
      B_MUL_X: begin
        mul_a = MA_W'(bx);
        mul_b = tp_s;
      end
      B_MUL_Y: begin
        mul_a = MA_W'(by);
        mul_b = tp_s;
      end
      B_MUL_XC: begin
        mul_a = dx;
        mul_b = c_r;
      end
      B_MUL_YS: begin
        mul_a = dy;
        mul_b = s_r;
      end
      B_MUL_XS: begin
        mul_a = dx;
        mul_b = s_r;
      end
      B_MUL_YC: begin
        mul_a = dy;
        mul_b = c_r;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      out_valid   <= 1'b0;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
    end else begin
      state <= state_next;
      if (state == B_UPD && out_free) begin
        out_valid   <= 1'b1;
        acc_x       <= new_x;
        acc_y       <= new_y;
        acc_heading <= heading_new;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= P_W'(mul_a) * P_W'(mul_b);
    case (state)
      B_IDLE: begin
        if (pop_valid) begin
          {ul, ur, ll, lr, bx, by, bt} <= pop_data;
        end
      end
      B_MUL_X: dth <= DTH_W'((prod + P_W'(2048)) >>> 12);
      B_MUL_Y: begin
        dx    <= DX_W'((prod + P_W'(32768)) >>> 16);
        r_mid <= RW'(acc_heading) + RW'(dth >>> 1) + RW'(PI_Q28);
        r_new <= RW'(acc_heading) + RW'(dth) + RW'(PI_Q28);
        step  <= STEP_W'(K);
      end
      B_WRAP: begin
        dy <= DX_W'((prod + P_W'(32768)) >>> 16);
        if (r_mid >= pk) begin
          r_mid <= r_mid - pk;
        end else if (r_mid < 0) begin
          r_mid <= r_mid + pk;
        end
        if (r_new >= pk) begin
          r_new <= r_new - pk;
        end else if (r_new < 0) begin
          r_new <= r_new + pk;
        end
        if (step != '0) step <= step - STEP_W'(1);
      end
      B_FOLD: begin
        heading_new <= HEAD_W'(n_fix - RW'(PI_Q28));
        x           <= CORDIC_GAIN;
        y           <= '0;
        step        <= '0;
        if (mid_ang > HALF_PI_Q28) begin
          z   <= mid_ang - PI_Q28;
          neg <= 1'b1;
        end else if (mid_ang < -HALF_PI_Q28) begin
          z   <= mid_ang + PI_Q28;
          neg <= 1'b1;
        end else begin
          z   <= mid_ang;
          neg <= 1'b0;
        end
      end
      B_CORDIC: begin
        if (z >= 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        if (step != STEP_W'(CORDIC_STEPS-1)) step <= step + STEP_W'(1);
      end
      B_MUL_YS: sumx <= SUM_W'(prod);
      B_MUL_XS: sumx <= sumx - SUM_W'(prod);
      B_MUL_YC: sumy <= SUM_W'(prod);
      B_SUM:    sumy <= sumy + SUM_W'(prod);
      B_UPD: begin
        if (out_free) begin
          res.wheel_upper_left  <= ul;
          res.wheel_upper_right <= ur;
          res.wheel_lower_left  <= ll;
          res.wheel_lower_right <= lr;
          res.pose_x            <= new_x;
          res.pose_y            <= new_y;
          res.pose_heading      <= heading_new;
          res.body_vel_x        <= bx;
          res.body_vel_y        <= by;
          res.body_vel_turn     <= bt;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid = out_valid;

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    (ANG_W'(acc_heading) >= -PI_Q28) && (ANG_W'(acc_heading) < PI_Q28))
    else $error("heading accumulator left its range");

  a_cordic_step: assert property (@(posedge clk) disable iff (rst)
    (state == B_CORDIC) |-> (step <= STEP_W'(CORDIC_STEPS-1)))
    else $error("cordic step past table end");

  a_wrap_step: assert property (@(posedge clk) disable iff (rst)
    (state == B_WRAP) |-> (step <= STEP_W'(K)))
    else $error("wrap step past its limit");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_CORDIC && step == '0) |-> (z >= -HALF_PI_Q28 && z <= HALF_PI_Q28))
    else $error("cordic angle not folded");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == B_UPD && out_free) |=> out_valid)
    else $error("result not presented after update");

endmodule

// ===== rtl/core/mecanum_kinematics_odometry.sv =====
`timescale 1ns / 1ps

// channel  dir  handshake      payload
// cmd      in   valid/ready    vel_forward, vel_lateral, vel_turn
// res      out  valid/ready    wheel speeds, pose, recovered body velocity
// cfg      in   valid/ready    index, data (always ready)
//
// front stage takes no new command until the last is pushed; a 2-entry queue sits before the back stage
// back stage works on one item at a time, K = VEL_WIDTH-16 (at least 2): one shared
// multiplier, K+1 heading wrap steps and 24 cordic steps
// synchronous active-high reset clears the pose and loads the register defaults
// a stalled result waits in the output register; the back stage holds its pose update

module mecanum_kinematics_odometry import mko_pkg::*; #(
  parameter int VEL_WIDTH = 24,
  parameter int POS_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  mko_cmd_if.sink   cmd,
  mko_res_if.source res,
  mko_cfg_if.sink   cfg
);

  localparam int ITEM_W = 7 * VEL_WIDTH;

  logic [HSS_W-1:0]  half_span_sum;
  logic [IHS_W-1:0]  inverse_half_span;
  logic [TP_W-1:0]   tick_period;
  logic              f_valid, f_ready, q_valid, q_ready;
  logic [ITEM_W-1:0] f_data, q_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_span_sum     <= HSS_RESET;
      inverse_half_span <= IHS_RESET;
      tick_period       <= TP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HALF_SPAN_SUM:     half_span_sum     <= cfg.data[HSS_W-1:0];
        REG_INVERSE_HALF_SPAN: inverse_half_span <= cfg.data[IHS_W-1:0];
        REG_TICK_PERIOD:       tick_period       <= cfg.data[TP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mko_front #(.VEL_WIDTH(VEL_WIDTH)) u_front (
    .clk               (clk),
    .rst               (rst),
    .half_span_sum     (half_span_sum),
    .inverse_half_span (inverse_half_span),
    .cmd               (cmd),
    .push_valid        (f_valid),
    .push_ready        (f_ready),
    .push_data         (f_data)
  );

  mko_queue #(.DATA_W(ITEM_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  mko_back #(.VEL_WIDTH(VEL_WIDTH), .POS_WIDTH(POS_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .tick_period (tick_period),
    .pop_valid   (q_valid),
    .pop_ready   (q_ready),
    .pop_data    (q_data),
    .res         (res)
  );

endmodule
